[hdl/srgmm_pkg.sv]
// Package for the sparse row group min/max reduce block.
// Holds sizes, field widths, request codes and configuration register indexes.
// No dependencies; the interfaces and the top level import it.
package srgmm_pkg;

    localparam int VEC_SIZE    = 1024;
    localparam int MAX_CHOICES = 16;
    localparam int XADDR_W     = $clog2(VEC_SIZE);

    localparam int OP_W  = 2;
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int OFF_W = 4;
    localparam int ACC_W = 64;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_NZ    = 2'd1,
        OP_EMPTY = 2'd2
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_MINIMIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_PLACE = 1'd1;

endpackage

[hdl/srgmm_in_if.sv]
// Request channel of the sparse row group min/max reduce block.
// Carries valid, ready and one load, nonzero or empty group request.
// Depends on srgmm_pkg.
interface srgmm_in_if;
    import srgmm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        index;
    logic [IDX_W-1:0]        group_index;
    logic signed [VAL_W-1:0] value;
    logic                    row_end;
    logic                    group_end;
    logic signed [VAL_W-1:0] bias;
    logic [OFF_W-1:0]        row_offset;
    logic [OFF_W-1:0]        prior_choice;

    modport source (
        output valid, op, index, group_index, value, row_end, group_end, bias,
               row_offset, prior_choice,
        input  ready
    );

    modport sink (
        input  valid, op, index, group_index, value, row_end, group_end, bias,
               row_offset, prior_choice,
        output ready
    );
endinterface

[hdl/srgmm_out_if.sv]
// Result channel of the sparse row group min/max reduce block.
// Carries valid, ready and one group result.
// Depends on srgmm_pkg.
interface srgmm_out_if;
    import srgmm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_group;
    logic signed [VAL_W-1:0] group_value;
    logic [OFF_W-1:0]        choice;
    logic                    choice_changed;

    modport source (
        output valid, out_group, group_value, choice, choice_changed,
        input  ready
    );

    modport sink (
        input  valid, out_group, group_value, choice, choice_changed,
        output ready
    );
endinterface

[hdl/sparse_row_group_min_max_reduce.sv]
// Top level of the sparse row group min/max reduce block (Bellman update).
// Depends on srgmm_pkg, srgmm_in_if, srgmm_out_if and srgmm_ram.
//
// Channel   Direction  Handshake        Contents
// i_req     in         valid / ready    op, index, group_index, value, row_end,
//                                       group_end, bias, row_offset, prior_choice
// o_rsp     out        valid / ready    out_group, group_value, choice, choice_changed
// i_cfg_*   in         write enable     register index, data (minimize, in_place)
//
// One request is taken per cycle while the pipeline advances and no hazard holds it;
// a group result passes through six pipeline stages around the x store RAM.
// A nonzero whose column is a group with an in-place write still in flight waits
// until that write reaches the last stage, and longer while the output stalls.
// A waiting result freezes the pipeline only when the last stage holds another.
// Reset is synchronous and clears control state; the x store is not cleared.
module sparse_row_group_min_max_reduce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srgmm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srgmm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    srgmm_in_if.sink                          i_req,
    srgmm_out_if.source                       o_rsp
);
    import srgmm_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        index;
        logic [IDX_W-1:0]        grp;
        logic signed [VAL_W-1:0] val;
        logic                    rend;
        logic                    gend;
        logic signed [VAL_W-1:0] bias;
        logic [OFF_W-1:0]        roff;
        logic [OFF_W-1:0]        prior;
        logic                    x_ok;
        logic                    g_ok;
        logic                    wip;
    } t_item;

    localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    function automatic logic better(
        input logic                    mn,
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return mn ? (a < b) : (a > b);
    endfunction

    logic r_minimize;
    logic r_in_place;

    logic [6:1] r_v;
    t_item      r_it [1:6];

    logic  adv;
    logic  hazard;
    logic  accept;
    t_item in_item;

    logic [VAL_W-1:0]        ram_rdata;
    logic                    ram_we;
    logic [XADDR_W-1:0]      ram_waddr;
    logic signed [VAL_W-1:0] ram_wdata;

    logic                    r_lw_v;
    logic [XADDR_W-1:0]      r_lw_addr;
    logic signed [VAL_W-1:0] r_lw_data;

    logic signed [VAL_W-1:0] x_fwd;
    logic signed [ACC_W-1:0] n_prod;
    logic signed [ACC_W-1:0] r_prod;

    logic signed [ACC_W-1:0] sum2;
    logic signed [ACC_W-1:0] r_row_sum;
    logic signed [ACC_W-1:0] n_row_sum;
    logic signed [ACC_W-1:0] r_sum3;
    logic signed [ACC_W-1:0] n_t4;
    logic signed [ACC_W-1:0] r_t4;
    logic signed [ACC_W-1:0] rounded;
    logic [ACC_W-17:0]       quot;
    logic signed [VAL_W-1:0] n_rv5;
    logic signed [VAL_W-1:0] r_rv5;

    logic signed [VAL_W-1:0] r_best_val, n_best_val, upd_best_val;
    logic [OFF_W-1:0]        r_best_off, n_best_off, upd_best_off;
    logic                    r_have,     n_have,     upd_have;
    logic signed [VAL_W-1:0] r_prior_val, n_prior_val, upd_prior_val;
    logic                    r_prior_seen, n_prior_seen, upd_prior_seen;

    logic signed [VAL_W-1:0] r_g6_best;
    logic [OFF_W-1:0]        r_g6_off;
    logic                    r_g6_have;
    logic signed [VAL_W-1:0] r_g6_pval;
    logic                    r_g6_pseen;

    logic                    res6;
    logic signed [VAL_W-1:0] gv6;
    logic [OFF_W-1:0]        choice6;

    logic                    r_out_v;
    logic [IDX_W-1:0]        r_out_group;
    logic signed [VAL_W-1:0] r_out_value;
    logic [OFF_W-1:0]        r_out_choice;
    logic                    r_out_changed;

    always_comb begin
        res6 = (r_it[6].op == OP_EMPTY) || ((r_it[6].op == OP_NZ) && r_it[6].gend);
        adv  = !(r_v[6] && res6 && r_out_v && !o_rsp.ready);
    end

    always_comb begin
        hazard = 1'b0;
        for (int k = 1; k <= 5; k++) begin
            if (r_v[k] && r_it[k].wip && (r_it[k].grp == i_req.index)) begin
                hazard = 1'b1;
            end
        end
        if (i_req.op != OP_NZ) begin
            hazard = 1'b0;
        end
    end

    assign i_req.ready = adv && !hazard;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        in_item.op    = i_req.op;
        in_item.index = i_req.index;
        in_item.grp   = i_req.group_index;
        in_item.val   = i_req.value;
        in_item.rend  = i_req.row_end || i_req.group_end;
        in_item.gend  = i_req.group_end;
        in_item.bias  = i_req.bias;
        in_item.roff  = i_req.row_offset;
        in_item.prior = i_req.prior_choice;
        in_item.x_ok  = 32'(i_req.index) < VEC_SIZE;
        in_item.g_ok  = 32'(i_req.group_index) < VEC_SIZE;
        in_item.wip   = (i_req.op == OP_NZ) && i_req.group_end && r_in_place;
    end

    srgmm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VEC_SIZE)
    ) u_x_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (i_req.index[XADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // The newest pending write to the same entry wins over the RAM data.
    always_comb begin
        x_fwd = ram_rdata;
        if (r_lw_v && (r_lw_addr == r_it[1].index[XADDR_W-1:0])) begin
            x_fwd = r_lw_data;
        end
        for (int k = 6; k >= 2; k--) begin
            if (r_v[k] && (r_it[k].op == OP_LOAD) && r_it[k].x_ok
                    && (r_it[k].index == r_it[1].index)) begin
                x_fwd = r_it[k].val;
            end
        end
        if (!r_it[1].x_ok) begin
            x_fwd = '0;
        end
        n_prod = r_it[1].val * x_fwd;
    end

    always_comb begin
        sum2      = sat_add(r_row_sum, r_prod);
        n_row_sum = r_row_sum;
        if (adv && r_v[2]) begin
            case (r_it[2].op)
                OP_NZ:    n_row_sum = r_it[2].rend ? '0 : sum2;
                OP_EMPTY: n_row_sum = '0;
                default:  n_row_sum = r_row_sum;
            endcase
        end
    end

    always_comb begin
        n_t4    = sat_add(r_sum3, {{(ACC_W-VAL_W-16){r_it[3].bias[VAL_W-1]}},
                                   r_it[3].bias, 16'd0});
        rounded = sat_add(r_t4, ROUND_HALF);
        quot    = rounded[ACC_W-1:16];
        if ((&quot[ACC_W-17:VAL_W-1]) || !(|quot[ACC_W-17:VAL_W-1])) begin
            n_rv5 = quot[VAL_W-1:0];
        end else begin
            n_rv5 = quot[ACC_W-17] ? VAL_MIN : VAL_MAX;
        end
    end

    always_comb begin
        upd_best_val   = r_best_val;
        upd_best_off   = r_best_off;
        upd_have       = r_have;
        upd_prior_val  = r_prior_val;
        upd_prior_seen = r_prior_seen;
        if (r_it[5].rend && (32'(r_it[5].roff) < MAX_CHOICES)) begin
            if (r_it[5].roff == r_it[5].prior) begin
                upd_prior_val  = r_rv5;
                upd_prior_seen = 1'b1;
            end
            if (!r_have || better(r_minimize, r_rv5, r_best_val)) begin
                upd_best_val = r_rv5;
                upd_best_off = r_it[5].roff;
                upd_have     = 1'b1;
            end
        end

        n_best_val   = r_best_val;
        n_best_off   = r_best_off;
        n_have       = r_have;
        n_prior_val  = r_prior_val;
        n_prior_seen = r_prior_seen;
        if (adv && r_v[5]) begin
            if ((r_it[5].op == OP_EMPTY) || ((r_it[5].op == OP_NZ) && r_it[5].gend)) begin
                n_best_val   = '0;
                n_best_off   = '0;
                n_have       = 1'b0;
                n_prior_val  = '0;
                n_prior_seen = 1'b0;
            end else if (r_it[5].op == OP_NZ) begin
                n_best_val   = upd_best_val;
                n_best_off   = upd_best_off;
                n_have       = upd_have;
                n_prior_val  = upd_prior_val;
                n_prior_seen = upd_prior_seen;
            end
        end
    end

    always_comb begin
        gv6     = '0;
        choice6 = r_it[6].prior;
        if ((r_it[6].op == OP_NZ) && r_g6_have) begin
            gv6 = r_g6_best;
            if (!r_g6_pseen || better(r_minimize, r_g6_best, r_g6_pval)) begin
                choice6 = r_g6_off;
            end
        end

        ram_we    = 1'b0;
        ram_waddr = r_it[6].index[XADDR_W-1:0];
        ram_wdata = r_it[6].val;
        if (adv && r_v[6]) begin
            if ((r_it[6].op == OP_LOAD) && r_it[6].x_ok) begin
                ram_we = 1'b1;
            end else if ((r_it[6].op == OP_NZ) && r_it[6].gend && r_g6_have
                    && r_in_place && r_it[6].g_ok) begin
                ram_we    = 1'b1;
                ram_waddr = r_it[6].grp[XADDR_W-1:0];
                ram_wdata = gv6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minimize   <= 1'b0;
            r_in_place   <= 1'b0;
            r_v          <= '0;
            r_lw_v       <= 1'b0;
            r_row_sum    <= '0;
            r_best_val   <= '0;
            r_best_off   <= '0;
            r_have       <= 1'b0;
            r_prior_val  <= '0;
            r_prior_seen <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MINIMIZE: r_minimize <= i_cfg_data[0];
                    CFG_IN_PLACE: r_in_place <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (adv) begin
                r_v    <= {r_v[5:1], accept && ((i_req.op == OP_LOAD)
                           || (i_req.op == OP_NZ) || (i_req.op == OP_EMPTY))};
                r_lw_v <= ram_we;
            end
            r_row_sum    <= n_row_sum;
            r_best_val   <= n_best_val;
            r_best_off   <= n_best_off;
            r_have       <= n_have;
            r_prior_val  <= n_prior_val;
            r_prior_seen <= n_prior_seen;
            if (adv && r_v[6] && res6) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_it[1] <= in_item;
            for (int k = 2; k <= 6; k++) begin
                r_it[k] <= r_it[k-1];
            end
            r_lw_addr  <= ram_waddr;
            r_lw_data  <= ram_wdata;
            r_prod     <= n_prod;
            r_sum3     <= sum2;
            r_t4       <= n_t4;
            r_rv5      <= n_rv5;
            r_g6_best  <= upd_best_val;
            r_g6_off   <= upd_best_off;
            r_g6_have  <= upd_have;
            r_g6_pval  <= upd_prior_val;
            r_g6_pseen <= upd_prior_seen;
            if (r_v[6] && res6) begin
                r_out_group   <= r_it[6].grp;
                r_out_value   <= gv6;
                r_out_choice  <= choice6;
                r_out_changed <= choice6 != r_it[6].prior;
            end
        end
    end

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.out_group      = r_out_group;
    assign o_rsp.group_value    = r_out_value;
    assign o_rsp.choice         = r_out_choice;
    assign o_rsp.choice_changed = r_out_changed;
endmodule

[hdl/srgmm_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// A read of the address written in the same cycle returns the old data.
// No dependencies.
module srgmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
